FILE: rtl/crpm_pkg.sv
package crpm_pkg;

  typedef enum logic [1:0] {
    REG_LINEAR = 2'd0,
    REG_SQUARE = 2'd1,
    REG_WEIGHT = 2'd2
  } reg_index_t;

  localparam int NUM_REGS = 3;

endpackage

FILE: rtl/curl_rational_point_map.sv
// Curl variation of a flame point, signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction).
// The slave stream carries one point and the running accumulator per beat; the master
// stream returns the updated accumulator, with the saturation flag in tuser.
// The registers c1, c2 and weight are written over the APB port; the user must write them
// only while the block is idle, which the block itself does not enforce. c1 and c2 reset
// to zero, weight to one. The pipeline has seven multiply and add stages, then one
// restoring divider stage per quotient bit for x and y side by side, then the final add
// and clamp. Throughput is one beat per cycle while the receiver does not stall;
// the divider pipeline depth sets the latency.
// Reset clears all valid bits and the registers. When the receiver stalls the whole
// pipeline holds, and input is refused only while the output register is full and
// not taken.
module curl_rational_point_map #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic clk,
  input  logic rst,
  // fields from bit 0: point_x, point_y, point_z, acc_x, acc_y, acc_z
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // fields from bit 0: sum_x, sum_y, sum_z
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [((3*DATA_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
  // fields from bit 0: overflow
  output logic [0:0]                              m_axis_tuser,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [((DATA_WIDTH>32)?5:4)-1:0]        paddr,
  input  logic [((DATA_WIDTH>32)?64:32)-1:0]      pwdata,
  output logic [((DATA_WIDTH>32)?64:32)-1:0]      prdata,
  output logic                                    pready
);
  import crpm_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NB = W + F;
  localparam int PW = (W > 32) ? 64 : 32;
  localparam int AW = (W > 32) ? 5 : 4;
  localparam int SH = (W > 32) ? 3 : 2;
  localparam int IB = ((6*W+7)/8)*8;
  localparam int OB = ((3*W+7)/8)*8;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [2*W-1:0] MAXW = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [2*W-1:0] MINW = {{(W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic               ONE_OV = (F >= W-1);
  localparam logic signed [W-1:0] ONE_V = (F >= W-1) ? MAXV : W'(64'd1 << F);
  localparam logic [NB-1:0] LIM_POS = {{(NB-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NB-1:0] LIM_NEG = {{(NB-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] mulq(input logic signed [W-1:0] a,
                                      input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    logic signed [2*W-1:0] s;
    p = a * b;
    s = p >>> F;
    if (s > MAXW) mulq = {1'b1, MAXV};
    else if (s < MINW) mulq = {1'b1, MINV};
    else mulq = {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W:0] addq(input logic signed [W-1:0] a,
                                      input logic signed [W-1:0] b, input logic sub);
    logic signed [W:0] s;
    if (sub) s = {a[W-1], a} - {b[W-1], b};
    else s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) addq = {1'b1, s[W] ? MINV : MAXV};
    else addq = {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W-1:0] magw(input logic signed [W-1:0] a);
    magw = a[W-1] ? W'(-a) : W'(a);
  endfunction

  function automatic logic [W+NB-1:0] div_step(input logic [W-1:0] rem,
                                               input logic [NB-1:0] nq,
                                               input logic [W-1:0] d);
    logic [W:0] t;
    logic qb;
    t = {rem, nq[NB-1]};
    qb = (t >= {1'b0, d});
    if (qb) t = t - {1'b0, d};
    div_step = {t[W-1:0], nq[NB-2:0], qb};
  endfunction

  function automatic logic [W:0] from_mag(input logic neg, input logic nneg,
                                          input logic dzero, input logic [NB-1:0] q);
    logic [W-1:0] m;
    m = q[W-1:0];
    if (dzero) from_mag = {1'b1, nneg ? MINV : MAXV};
    else if (q > (neg ? LIM_NEG : LIM_POS)) from_mag = {1'b1, neg ? MINV : MAXV};
    else from_mag = {1'b0, neg ? W'(-m) : m};
  endfunction

  // Configuration registers.
  logic signed [W-1:0] c1, c2, wt;
  logic [AW-SH-1:0] ridx;
  assign ridx   = paddr[AW-1:SH];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      wt <= ONE_V;
    end else if (psel && penable && pwrite) begin
      if (ridx == (AW-SH)'(REG_LINEAR)) c1 <= pwdata[W-1:0];
      if (ridx == (AW-SH)'(REG_SQUARE)) c2 <= pwdata[W-1:0];
      if (ridx == (AW-SH)'(REG_WEIGHT)) wt <= pwdata[W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (ridx == (AW-SH)'(REG_LINEAR)) prdata[W-1:0] = c1;
    else if (ridx == (AW-SH)'(REG_SQUARE)) prdata[W-1:0] = c2;
    else if (ridx == (AW-SH)'(REG_WEIGHT)) prdata[W-1:0] = wt;
  end

  // Pipeline control: every stage moves together.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [W-1:0] in_x, in_y, in_z, in_ax, in_ay, in_az;
  assign in_x  = s_axis_tdata[0*W +: W];
  assign in_y  = s_axis_tdata[1*W +: W];
  assign in_z  = s_axis_tdata[2*W +: W];
  assign in_ax = s_axis_tdata[3*W +: W];
  assign in_ay = s_axis_tdata[4*W +: W];
  assign in_az = s_axis_tdata[5*W +: W];

  logic v1, v2, v3, v4, v5, v6, v7;
  logic signed [W-1:0] x1, y1, ax1, ay1, az1, xx1, yy1, xy1, c1x1, c1y1, wz1;
  logic ov1;
  logic signed [W-1:0] x2, y2, ax2, ay2, sz2, a2, b2, r02, c1y2;
  logic ov2;
  logic signed [W-1:0] x3, y3, ax3, ay3, sz3, m13, m23, r03, c1y3;
  logic ov3;
  logic signed [W-1:0] x4, y4, ax4, ay4, sz4, re4, im4;
  logic ov4;
  logic signed [W-1:0] ax5, ay5, sz5, rr5, ii5, xr5, yi5, yr5, xi5;
  logic ov5;
  logic signed [W-1:0] ax6, ay6, sz6, den6, nx6, ny6;
  logic ov6;
  logic signed [W-1:0] ax7, ay7, sz7, den7, wnx7, wny7;
  logic ov7;

  logic [W:0] m_xx, m_yy, m_xy, m_c1x, m_c1y, m_wz;
  logic [W:0] s_a, s_b, s_r0, s_sz, m_1, m_2, s_re, s_im;
  logic [W:0] m_rr, m_ii, m_xr, m_yi, m_yr, m_xi, s_den, s_nx, s_ny, m_wnx, m_wny;

  always_comb begin
    m_xx  = mulq(in_x, in_x);
    m_yy  = mulq(in_y, in_y);
    m_xy  = mulq(in_x, in_y);
    m_c1x = mulq(c1, in_x);
    m_c1y = mulq(c1, in_y);
    m_wz  = mulq(wt, in_z);
    s_a   = addq(xx1, yy1, 1'b1);
    s_b   = addq(xy1, xy1, 1'b0);
    s_r0  = addq(ONE_V, c1x1, 1'b0);
    s_sz  = addq(az1, wz1, 1'b0);
    m_1   = mulq(c2, a2);
    m_2   = mulq(c2, b2);
    s_re  = addq(r03, m13, 1'b0);
    s_im  = addq(c1y3, m23, 1'b0);
    m_rr  = mulq(re4, re4);
    m_ii  = mulq(im4, im4);
    m_xr  = mulq(x4, re4);
    m_yi  = mulq(y4, im4);
    m_yr  = mulq(y4, re4);
    m_xi  = mulq(x4, im4);
    s_den = addq(rr5, ii5, 1'b0);
    s_nx  = addq(xr5, yi5, 1'b0);
    s_ny  = addq(yr5, xi5, 1'b1);
    m_wnx = mulq(wt, nx6);
    m_wny = mulq(wt, ny6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= in_x; y1 <= in_y; ax1 <= in_ax; ay1 <= in_ay; az1 <= in_az;
      xx1 <= m_xx[W-1:0]; yy1 <= m_yy[W-1:0]; xy1 <= m_xy[W-1:0];
      c1x1 <= m_c1x[W-1:0]; c1y1 <= m_c1y[W-1:0]; wz1 <= m_wz[W-1:0];
      ov1 <= ONE_OV | m_xx[W] | m_yy[W] | m_xy[W] | m_c1x[W] | m_c1y[W] | m_wz[W];

      x2 <= x1; y2 <= y1; ax2 <= ax1; ay2 <= ay1; c1y2 <= c1y1;
      a2 <= s_a[W-1:0]; b2 <= s_b[W-1:0]; r02 <= s_r0[W-1:0]; sz2 <= s_sz[W-1:0];
      ov2 <= ov1 | s_a[W] | s_b[W] | s_r0[W] | s_sz[W];

      x3 <= x2; y3 <= y2; ax3 <= ax2; ay3 <= ay2; sz3 <= sz2; r03 <= r02; c1y3 <= c1y2;
      m13 <= m_1[W-1:0]; m23 <= m_2[W-1:0];
      ov3 <= ov2 | m_1[W] | m_2[W];

      x4 <= x3; y4 <= y3; ax4 <= ax3; ay4 <= ay3; sz4 <= sz3;
      re4 <= s_re[W-1:0]; im4 <= s_im[W-1:0];
      ov4 <= ov3 | s_re[W] | s_im[W];

      ax5 <= ax4; ay5 <= ay4; sz5 <= sz4;
      rr5 <= m_rr[W-1:0]; ii5 <= m_ii[W-1:0]; xr5 <= m_xr[W-1:0];
      yi5 <= m_yi[W-1:0]; yr5 <= m_yr[W-1:0]; xi5 <= m_xi[W-1:0];
      ov5 <= ov4 | m_rr[W] | m_ii[W] | m_xr[W] | m_yi[W] | m_yr[W] | m_xi[W];

      ax6 <= ax5; ay6 <= ay5; sz6 <= sz5;
      den6 <= s_den[W-1:0]; nx6 <= s_nx[W-1:0]; ny6 <= s_ny[W-1:0];
      ov6 <= ov5 | s_den[W] | s_nx[W] | s_ny[W];

      ax7 <= ax6; ay7 <= ay6; sz7 <= sz6; den7 <= den6;
      wnx7 <= m_wnx[W-1:0]; wny7 <= m_wny[W-1:0];
      ov7 <= ov6 | m_wnx[W] | m_wny[W];
    end
  end

  // Restoring dividers for x and y, one quotient bit per stage.
  logic              dv    [0:NB];
  logic [NB-1:0]     nqx   [0:NB];
  logic [NB-1:0]     nqy   [0:NB];
  logic [W-1:0]      remx  [0:NB];
  logic [W-1:0]      remy  [0:NB];
  logic [W-1:0]      dm    [0:NB];
  logic              dz    [0:NB];
  logic              negx  [0:NB];
  logic              negy  [0:NB];
  logic              nnx   [0:NB];
  logic              nny   [0:NB];
  logic signed [W-1:0] dax [0:NB];
  logic signed [W-1:0] day [0:NB];
  logic signed [W-1:0] dsz [0:NB];
  logic              dov   [0:NB];

  logic [W+NB-1:0] stx [1:NB];
  logic [W+NB-1:0] sty [1:NB];

  always_comb begin
    for (int k = 1; k <= NB; k++) begin
      stx[k] = div_step(remx[k-1], nqx[k-1], dm[k-1]);
      sty[k] = div_step(remy[k-1], nqy[k-1], dm[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NB; k++) dv[k] <= 1'b0;
    end else if (en) begin
      dv[0] <= v7;
      for (int k = 1; k <= NB; k++) dv[k] <= dv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nqx[0]  <= {magw(wnx7), {F{1'b0}}};
      nqy[0]  <= {magw(wny7), {F{1'b0}}};
      remx[0] <= '0;
      remy[0] <= '0;
      dm[0]   <= magw(den7);
      dz[0]   <= (den7 == '0);
      negx[0] <= wnx7[W-1] ^ den7[W-1];
      negy[0] <= wny7[W-1] ^ den7[W-1];
      nnx[0]  <= wnx7[W-1];
      nny[0]  <= wny7[W-1];
      dax[0]  <= ax7;
      day[0]  <= ay7;
      dsz[0]  <= sz7;
      dov[0]  <= ov7;
      for (int k = 1; k <= NB; k++) begin
        remx[k] <= stx[k][W+NB-1:NB];
        nqx[k]  <= stx[k][NB-1:0];
        remy[k] <= sty[k][W+NB-1:NB];
        nqy[k]  <= sty[k][NB-1:0];
        dm[k]   <= dm[k-1];
        dz[k]   <= dz[k-1];
        negx[k] <= negx[k-1];
        negy[k] <= negy[k-1];
        nnx[k]  <= nnx[k-1];
        nny[k]  <= nny[k-1];
        dax[k]  <= dax[k-1];
        day[k]  <= day[k-1];
        dsz[k]  <= dsz[k-1];
        dov[k]  <= dov[k-1];
      end
    end
  end

  // Final clamp of the quotients and accumulation.
  logic [W:0] qx, qy, fx, fy;
  always_comb begin
    qx = from_mag(negx[NB], nnx[NB], dz[NB], nqx[NB]);
    qy = from_mag(negy[NB], nny[NB], dz[NB], nqy[NB]);
    fx = addq(dax[NB], qx[W-1:0], 1'b0);
    fy = addq(day[NB], qy[W-1:0], 1'b0);
  end

  logic signed [W-1:0] sum_x, sum_y, sum_z;
  logic overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_x    <= fx[W-1:0];
      sum_y    <= fy[W-1:0];
      sum_z    <= dsz[NB];
      overflow <= dov[NB] | qx[W] | qy[W] | fx[W] | fy[W];
    end
  end

  always_comb begin
    m_axis_tdata          = '0;
    m_axis_tdata[0*W +: W] = sum_x;
    m_axis_tdata[1*W +: W] = sum_y;
    m_axis_tdata[2*W +: W] = sum_z;
    m_axis_tuser          = overflow;
  end

endmodule

FILE: dv/curl_point_checker.sv
`timescale 1ns / 100ps

module curl_point_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending_sums,
  output int           sums_seen,
  output int           overflow_seen
);
  import crpm_pkg::*;

  localparam int FB = 24;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  longint c1, c2, wt;
  logic [96:0] sum_q[$];

  function automatic longint clampv(longint v, ref bit ov);
    if (v > MAXV) begin
      ov = 1;
      return MAXV;
    end
    if (v < MINV) begin
      ov = 1;
      return MINV;
    end
    return v;
  endfunction

  // Exact product, floor shift, clamp.
  function automatic longint qmul(longint a, longint b, ref bit ov);
    logic signed [127:0] p;
    p = (128'(signed'(a)) * 128'(signed'(b))) >>> FB;
    if (p > 128'(signed'(MAXV))) begin
      ov = 1;
      return MAXV;
    end
    if (p < 128'(signed'(MINV))) begin
      ov = 1;
      return MINV;
    end
    return longint'(p);
  endfunction

  function automatic longint qdiv(longint n, longint d, ref bit ov);
    logic signed [127:0] num, q;
    if (d == 0) begin
      ov = 1;
      return (n < 0) ? MINV : MAXV;
    end
    num = 128'(signed'(n)) <<< FB;
    q = num / 128'(signed'(d));
    if (q > 128'(signed'(MAXV))) begin
      ov = 1;
      return MAXV;
    end
    if (q < 128'(signed'(MINV))) begin
      ov = 1;
      return MINV;
    end
    return longint'(q);
  endfunction

  function automatic logic [96:0] curl_sum(logic [191:0] d);
    longint x, y, z, ax, ay, az, xx, yy, xy, re, im, den, nx, ny, cx, cy, cz;
    bit ov;
    ov = 0;
    x = longint'(signed'(d[31:0]));
    y = longint'(signed'(d[63:32]));
    z = longint'(signed'(d[95:64]));
    ax = longint'(signed'(d[127:96]));
    ay = longint'(signed'(d[159:128]));
    az = longint'(signed'(d[191:160]));
    xx = qmul(x, x, ov);
    yy = qmul(y, y, ov);
    xy = qmul(x, y, ov);
    re = clampv((64'sd1 <<< FB) + qmul(c1, x, ov), ov);
    re = clampv(re + qmul(c2, clampv(xx - yy, ov), ov), ov);
    im = qmul(c1, y, ov);
    im = clampv(im + qmul(c2, clampv(xy + xy, ov), ov), ov);
    den = clampv(qmul(re, re, ov) + qmul(im, im, ov), ov);
    nx = clampv(qmul(x, re, ov) + qmul(y, im, ov), ov);
    ny = clampv(qmul(y, re, ov) - qmul(x, im, ov), ov);
    cx = qdiv(qmul(wt, nx, ov), den, ov);
    cy = qdiv(qmul(wt, ny, ov), den, ov);
    cz = qmul(wt, z, ov);
    ax = clampv(ax + cx, ov);
    ay = clampv(ay + cy, ov);
    az = clampv(az + cz, ov);
    return {ov, az[31:0], ay[31:0], ax[31:0]};
  endfunction

  assign pending_sums = sum_q.size();

  always @(posedge clk) begin
    logic [96:0] want;
    if (rst) begin
      c1 <= 0;
      c2 <= 0;
      wt <= 64'sd1 <<< FB;
      fail_count <= 0;
      sums_seen <= 0;
      overflow_seen <= 0;
      sum_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LINEAR: c1 <= longint'(signed'(pwdata));
          REG_SQUARE: c2 <= longint'(signed'(pwdata));
          REG_WEIGHT: wt <= longint'(signed'(pwdata));
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) sum_q.push_back(curl_sum(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        sums_seen <= sums_seen + 1;
        if (m_axis_tuser[0]) overflow_seen <= overflow_seen + 1;
        if (sum_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %h/%b", $time, m_axis_tdata, m_axis_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = sum_q.pop_front();
          if (m_axis_tdata !== want[95:0] || m_axis_tuser[0] !== want[96]) begin
            $display("%0t: mismatch, expected %h/%b actual %h/%b", $time,
                     want[95:0], want[96], m_axis_tdata, m_axis_tuser[0]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/tb_curl_rational_point_map.sv
`timescale 1ns / 100ps

module tb_curl_rational_point_map;
  import crpm_pkg::*;

  localparam int LATENCY = 65;
  localparam int STALL_LIMIT = 20000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [95:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int fail_count, pending_sums, sums_seen, overflow_seen;
  int idle_cycles = 0;
  int points_sent = 0;
  bit calm_rx = 0, hold_rx = 0;

  curl_rational_point_map uut (.*);
  curl_point_checker chk (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_rx) m_axis_tready <= 0;
    else if (calm_rx) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(99) >= 9);
  end

  task automatic reg_write(reg_index_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic send_point(logic [31:0] x, y, z, ax, ay, az, bit calm);
    if (!calm) begin
      if ($urandom_range(99) < 9) begin
        s_axis_tvalid <= 0;
        @(negedge clk);
        while ($urandom_range(99) < 9) @(negedge clk);
      end
    end
    s_axis_tdata <= {az, ay, ax, z, y, x};
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    points_sent++;
  endtask

  task automatic stop_points();
    s_axis_tvalid <= 0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(8)) - 4) <<< ($urandom_range(26));
      default: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
    endcase
  endfunction

  task automatic drain();
    while (pending_sums != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  logic [31:0] edge_vals[6] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h01000000,
                               32'hff000000, 32'h00000001};
  logic [31:0] cfg_sets[7][3] = '{
    '{32'h0, 32'h0, 32'h01000000},
    '{32'h7fffffff, 32'h80000000, 32'h7fffffff},
    '{32'h80000000, 32'h7fffffff, 32'h80000000},
    '{32'hff000000, 32'h0, 32'h01000000},
    '{32'h0, 32'hff000000, 32'h00800000},
    '{32'h00400000, 32'h00200000, 32'hff000000},
    '{32'h0, 32'h0, 32'h0}};

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // Denominator zero: q = -1 with c1 = 1 gives d = 0.
    reg_write(REG_LINEAR, 32'h01000000);
    send_point(32'hff000000, 0, 32'h01000000, 0, 0, 0, 0);
    send_point(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0);
    stop_points();
    drain();
    reg_write(REG_LINEAR, 0);
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 3; j++)
        send_point(edge_vals[i], edge_vals[(i + j) % 6], edge_vals[j],
                   edge_vals[5 - i], edge_vals[(i + 2) % 6], edge_vals[j + 3], 0);
    stop_points();
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      int k;
      k = (ph < 7) ? ph : 5;
      if (ph == 7) begin
        reg_write(REG_LINEAR, $urandom());
        reg_write(REG_SQUARE, $urandom());
        reg_write(REG_WEIGHT, $urandom());
      end else begin
        reg_write(REG_LINEAR, cfg_sets[k][0]);
        reg_write(REG_SQUARE, cfg_sets[k][1]);
        reg_write(REG_WEIGHT, cfg_sets[k][2]);
      end
      if (ph == 2) fork
        begin
          hold_rx = 1;
          repeat (300) @(negedge clk);
          hold_rx = 0;
        end
      join_none
      calm_rx = (ph == 3);
      for (int n = 0; n < 200; n++)
        send_point(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord(), ph == 3);
      stop_points();
      calm_rx = 0;
      drain();
    end
    $display("Sent %0d points over 8 coefficient settings; %0d sums checked, %0d saturated.",
             points_sent, sums_seen, overflow_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
